[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LCDFB_ASSERT_HOLDS(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");

// Antecedent at one edge implies the consequent sequence from that edge.
`define LCDFB_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("%m: assertion failed");

`endif

[hw/rtl/lcdfb_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// lcdfb_pkg
// Shared constants and types of the LCD frame buffer refresh core.
// ============================================================================
package lcdfb_pkg;

  localparam int COLUMNS_DEFAULT = 128;
  localparam int ROWS_DEFAULT    = 64;

  // Operation codes
  localparam logic [2:0] OP_SET     = 3'd0;
  localparam logic [2:0] OP_GET     = 3'd1;
  localparam logic [2:0] OP_CLEAR   = 3'd2;
  localparam logic [2:0] OP_MARK    = 3'd3;
  localparam logic [2:0] OP_UP      = 3'd4;
  localparam logic [2:0] OP_DOWN    = 3'd5;
  localparam logic [2:0] OP_REFRESH = 3'd6;

  // Result kinds
  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_CMD   = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;

  // Panel command bytes
  localparam logic [7:0] CMD_PAGE_BASE = 8'hb0;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
  localparam logic [3:0] NIBBLE_MASK   = 4'h0f;

  // Configuration port
  localparam int         CFG_AW            = 3;
  localparam logic [0:0] REG_COLUMN_OFFSET = 1'b0;

  typedef struct packed {
    logic frame;
    logic dirty;
  } store_wen_t;

endpackage

[hw/rtl/lcdfb_store.sv]
`timescale 1ns / 1ps
// ============================================================================
// lcdfb_store
// Frame column memory and dirty page memory, one shared write address and
// one shared read address, read data registered.
// ============================================================================
module lcdfb_store #(
  parameter int COLUMNS = lcdfb_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = lcdfb_pkg::ROWS_DEFAULT,
  localparam int PAGES  = ROWS / 8,
  localparam int FW     = PAGES * 8,
  localparam int AW     = $clog2(COLUMNS)
) (
  input  logic                   clk,
  input  logic [AW-1:0]          rd_addr,
  input  logic [AW-1:0]          wr_addr,
  input  lcdfb_pkg::store_wen_t  wen,
  input  logic [FW-1:0]          frame_wdata,
  input  logic [PAGES-1:0]       dirty_wdata,
  output logic [FW-1:0]          frame_rdata,
  output logic [PAGES-1:0]       dirty_rdata
);

  logic [FW-1:0]    frame_mem [COLUMNS];
  logic [PAGES-1:0] dirty_mem [COLUMNS];

  always_ff @(posedge clk) begin
    if (wen.frame) begin
      frame_mem[wr_addr] <= frame_wdata;
    end
    frame_rdata <= frame_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wen.dirty) begin
      dirty_mem[wr_addr] <= dirty_wdata;
    end
    dirty_rdata <= dirty_mem[rd_addr];
  end

endmodule

[hw/rtl/lcd_framebuffer_dirty_refresh_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// lcd_framebuffer_dirty_refresh_core
// Monochrome page-addressed frame buffer with dirty tracking and panel refresh.
// ============================================================================
// Usage:
//   A request is taken when start is high and busy is low. Its results leave
//   on kind/value/pass_done, one per cycle, each marked by strobe for exactly
//   one cycle; the receiver cannot hold them off.
//   Steps per request: set pixel passes through S_SET, get pixel through
//     S_GET, which strobes the answer; a refresh step passes through S_REF,
//     then S_EMIT while it emits its bytes (0 to 4); a refresh with no pass
//     open and nothing pending leaves busy low; clear, mark all dirty and
//     scroll walk every column, one column per cycle through the memory port.
//   A set pixel request is a read-modify-write of one column entry in the frame
//   and dirty memories; the next request reads only after the write is done.
//   Reset: a clearing pass zeroes both memories; busy stays high meanwhile.
//   Register column_offset sits at APB address 0; it is to be written only
//   while the block is idle, which the block itself does not enforce.
// ============================================================================
module lcd_framebuffer_dirty_refresh_core #(
  parameter int COLUMNS = lcdfb_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = lcdfb_pkg::ROWS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   operation,
  input  logic [7:0]                   pos_x,
  input  logic [6:0]                   pos_y,
  input  logic                         color,
  input  logic [7:0]                   scroll_pixels,
  output logic                         strobe,
  output logic [1:0]                   kind,
  output logic [7:0]                   value,
  output logic                         pass_done,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lcdfb_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int PAGES = ROWS / 8;
  localparam int FW    = PAGES * 8;
  localparam int AW    = $clog2(COLUMNS);
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int YW    = $clog2(FW);

  typedef enum logic [2:0] {
    S_SWEEP, S_IDLE, S_SET, S_GET, S_SCROLL, S_REF, S_EMIT
  } state_t;

  state_t state;

  // Configuration
  logic [3:0] column_offset;
  logic       cfg_sel;

  assign cfg_sel = (paddr[lcdfb_pkg::CFG_AW-1:2] == lcdfb_pkg::REG_COLUMN_OFFSET);
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? 32'(column_offset) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_offset <= 4'd0;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      column_offset <= pwdata[3:0];
    end
  end

  // Request and scan registers
  logic [AW-1:0]    cnt;
  logic [AW-1:0]    x_q;
  logic [YW-1:0]    ybit_q;
  logic [PW-1:0]    ypage_q;
  logic             color_q;
  logic             valid_q;
  logic [4:0]       step_q;
  logic             scroll_up;
  logic             sweep_frame;
  logic             sweep_mark;
  logic             pending;
  logic             scan_active;
  logic [PW-1:0]    scan_page;
  logic [AW-1:0]    scan_col;
  logic             run;
  logic [1:0]       q_kind [4];
  logic [7:0]       q_val  [4];
  logic [2:0]       q_n;
  logic [1:0]       q_idx;
  logic             pass_end;

  // Memory port
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  lcdfb_pkg::store_wen_t wen;
  logic [FW-1:0]         frame_wdata;
  logic [PAGES-1:0]      dirty_wdata;
  logic [FW-1:0]         frame_rd;
  logic [PAGES-1:0]      dirty_rd;

  lcdfb_store #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_store (
    .clk         (clk),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .wen         (wen),
    .frame_wdata (frame_wdata),
    .dirty_wdata (dirty_wdata),
    .frame_rdata (frame_rd),
    .dirty_rdata (dirty_rd)
  );

  logic accept;
  logic in_valid;
  logic scroll_ok;
  logic pixel_change;
  logic page_hit;
  logic [PAGES-1:0] ref_bit;
  logic [PAGES-1:0] set_bit;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign in_valid  = (9'(pos_x) < 9'(COLUMNS)) && (8'(pos_y) < 8'(FW));
  assign scroll_ok = (9'(scroll_pixels) < 9'(ROWS)) && (scroll_pixels[7:3] != 5'd0);

  assign pixel_change = frame_rd[ybit_q] != color_q;
  assign set_bit      = PAGES'(1) << ypage_q;
  assign ref_bit      = PAGES'(1) << scan_page;
  assign page_hit     = |(dirty_rd & ref_bit);

  // Read address: the request's column at accept (the scan column for a refresh), the next column in a scroll
  always_comb begin
    if (state == S_SCROLL) begin
      rd_addr = cnt + AW'(1);
    end else begin
      case (operation)
        lcdfb_pkg::OP_REFRESH: rd_addr = scan_active ? scan_col : '0;
        lcdfb_pkg::OP_UP,
        lcdfb_pkg::OP_DOWN:    rd_addr = '0;
        default:               rd_addr = AW'(pos_x);
      endcase
    end
  end

  always_comb begin
    wen         = '0;
    wr_addr     = cnt;
    frame_wdata = '0;
    dirty_wdata = '0;
    case (state)
      S_SWEEP: begin
        wen.frame   = sweep_frame;
        wen.dirty   = 1'b1;
        dirty_wdata = sweep_mark ? '1 : '0;
      end
      S_SCROLL: begin
        wen.frame   = 1'b1;
        wen.dirty   = 1'b1;
        frame_wdata = scroll_up ? (frame_rd >> {step_q, 3'b000})
                                : (frame_rd << {step_q, 3'b000});
        dirty_wdata = '1;
      end
      S_SET: begin
        wr_addr     = x_q;
        wen.frame   = pixel_change;
        wen.dirty   = pixel_change;
        frame_wdata = frame_rd;
        frame_wdata[ybit_q] = color_q;
        dirty_wdata = dirty_rd | set_bit;
      end
      S_REF: begin
        wr_addr     = scan_col;
        wen.dirty   = page_hit;
        dirty_wdata = dirty_rd & ~ref_bit;
      end
      default: begin
      end
    endcase
  end

  // Bytes of one refresh position
  logic [1:0] r_kind [4];
  logic [7:0] r_val  [4];
  logic [2:0] r_n;
  logic       r_run;
  logic [7:0] col_addr;

  assign col_addr = 8'(scan_col) + 8'(column_offset);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      r_kind[i] = lcdfb_pkg::KIND_CMD;
      r_val[i]  = 8'd0;
    end
    r_n   = 3'd0;
    r_run = run;
    if (scan_col == '0) begin
      r_val[0] = lcdfb_pkg::CMD_PAGE_BASE + 8'(scan_page);
      r_n      = 3'd1;
      r_run    = 1'b0;
    end
    if (page_hit) begin
      if (!r_run) begin
        r_val[r_n[1:0]] = lcdfb_pkg::CMD_COL_HIGH | {4'd0, col_addr[7:4] & lcdfb_pkg::NIBBLE_MASK};
        r_n = r_n + 3'd1;
        r_val[r_n[1:0]] = {4'd0, col_addr[3:0] & lcdfb_pkg::NIBBLE_MASK};
        r_n = r_n + 3'd1;
      end
      r_kind[r_n[1:0]] = lcdfb_pkg::KIND_DATA;
      r_val[r_n[1:0]]  = 8'(frame_rd >> {scan_page, 3'b000});
      r_n   = r_n + 3'd1;
      r_run = 1'b1;
    end else begin
      r_run = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      cnt         <= '0;
      sweep_frame <= 1'b1;
      sweep_mark  <= 1'b0;
      pending     <= 1'b0;
      scan_active <= 1'b0;
      scan_page   <= '0;
      scan_col    <= '0;
      run         <= 1'b0;
      q_idx       <= 2'd0;
      strobe      <= 1'b0;
      pass_done   <= 1'b0;
    end else begin
      strobe    <= 1'b0;
      pass_done <= 1'b0;
      case (state)
        S_SWEEP: begin
          cnt <= cnt + AW'(1);
          if (cnt == AW'(COLUMNS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            x_q     <= AW'(pos_x);
            ybit_q  <= YW'(pos_y);
            ypage_q <= PW'(pos_y >> 3);
            color_q <= color;
            valid_q <= in_valid;
            step_q  <= scroll_pixels[7:3];
            cnt     <= '0;
            case (operation)
              lcdfb_pkg::OP_SET: begin
                if (in_valid) begin
                  state <= S_SET;
                end
              end
              lcdfb_pkg::OP_GET: begin
                state <= S_GET;
              end
              lcdfb_pkg::OP_CLEAR, lcdfb_pkg::OP_MARK: begin
                sweep_frame <= (operation == lcdfb_pkg::OP_CLEAR);
                sweep_mark  <= 1'b1;
                pending     <= 1'b1;
                state       <= S_SWEEP;
              end
              lcdfb_pkg::OP_UP, lcdfb_pkg::OP_DOWN: begin
                if (scroll_ok) begin
                  scroll_up <= (operation == lcdfb_pkg::OP_UP);
                  pending   <= 1'b1;
                  state     <= S_SCROLL;
                end
              end
              lcdfb_pkg::OP_REFRESH: begin
                if (!scan_active && pending) begin
                  // open a new pass
                  scan_active <= 1'b1;
                  pending     <= 1'b0;
                  scan_page   <= '0;
                  scan_col    <= '0;
                  run         <= 1'b0;
                  state       <= S_REF;
                end else if (scan_active) begin
                  state <= S_REF;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SET: begin
          if (pixel_change) begin
            pending <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_GET: begin
          strobe <= 1'b1;
          kind   <= lcdfb_pkg::KIND_PIXEL;
          value  <= valid_q ? {7'd0, frame_rd[ybit_q]} : 8'd0;
          state  <= S_IDLE;
        end
        S_SCROLL: begin
          cnt <= cnt + AW'(1);
          if (cnt == AW'(COLUMNS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_REF: begin
          q_kind   <= r_kind;
          q_val    <= r_val;
          q_n      <= r_n;
          q_idx    <= 2'd0;
          run      <= r_run;
          pass_end <= 1'b0;
          if (scan_col == AW'(COLUMNS - 1)) begin
            scan_col <= '0;
            if (scan_page == PW'(PAGES - 1)) begin
              scan_page   <= '0;
              scan_active <= 1'b0;
              run         <= 1'b0;
              pass_end    <= 1'b1;
            end else begin
              scan_page <= scan_page + PW'(1);
            end
          end else begin
            scan_col <= scan_col + AW'(1);
          end
          state <= (r_n == 3'd0) ? S_IDLE : S_EMIT;
        end
        S_EMIT: begin
          strobe    <= 1'b1;
          kind      <= q_kind[q_idx];
          value     <= q_val[q_idx];
          pass_done <= pass_end && ({1'b0, q_idx} + 3'd1 == q_n);
          if ({1'b0, q_idx} + 3'd1 == q_n) begin
            state <= S_IDLE;
          end else begin
            q_idx <= q_idx + 2'd1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/lcdfb_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// lcdfb_checker
// Port-level checks of the frame buffer refresh core, bound to the top level.
// ============================================================================
`include "assert_macros.svh"

module lcdfb_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [2:0] operation,
  input logic       strobe,
  input logic [1:0] kind,
  input logic [7:0] value,
  input logic       pass_done
);

  // reset starts the clearing pass
  `LCDFB_ASSERT_IMP(a_reset_busy, clk, 1'b0, rst, ##1 busy)

  // a pixel read is answered by a strobed pixel result
  `LCDFB_ASSERT_IMP(a_get_answer, clk, rst, start && !busy && operation == lcdfb_pkg::OP_GET, ##2 (strobe && kind == lcdfb_pkg::KIND_PIXEL))

  `LCDFB_ASSERT_IMP(a_pixel_bit, clk, rst, strobe && kind == lcdfb_pkg::KIND_PIXEL, (value[7:1] == 7'd0 && !pass_done))

  `LCDFB_ASSERT_IMP(a_cmd_byte, clk, rst, strobe && kind == lcdfb_pkg::KIND_CMD, (value[7:4] == 4'hb || value[7:4] == 4'h1 || value[7:4] == 4'h0))

  `LCDFB_ASSERT_HOLDS(a_pass_done_strobed, clk, rst, !pass_done || (strobe && kind != lcdfb_pkg::KIND_PIXEL))

endmodule

bind lcd_framebuffer_dirty_refresh_core lcdfb_checker u_lcdfb_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .operation (operation),
  .strobe    (strobe),
  .kind      (kind),
  .value     (value),
  .pass_done (pass_done)
);
